// ===== rtl/lir_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lir_pkg: shared definitions for the linear interpolation resampler
// Default widths, command and register codes, and the csr write bundle.
// ----------------------------------------------------------------------------
package lir_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int SAMPLE_BITS_DEF = 16;

   // phase holds up to one plus the largest step, that is below 16.0
   localparam int PHASE_EXTRA = 4;

   localparam int STEP_BITS      = 20;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 20;

   localparam int MAX_OUT     = 8;
   localparam int CNT_BITS    = $clog2(MAX_OUT + 1);
   localparam int QUEUE_DEPTH = 2;

   localparam logic CMD_FRAME   = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASE_STEP  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEREO_MODE = 1'b1;

   typedef struct packed {
      logic                      valid;
      logic [CSR_INDEX_BITS-1:0] reg_index;
      logic [CSR_DATA_BITS-1:0]  wdata;
   } csr_write_type;

   // width of one queued job: four samples, start phase, step, count, mono
   function automatic int job_bits(int sb, int fb);
      return 4 * sb + 2 * (fb + PHASE_EXTRA) + CNT_BITS + 1;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/lir_channels.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lir channels: valid/ready interfaces of the resampler
// Sample input, interpolated output and csr write channels.
// ----------------------------------------------------------------------------
interface lir_req_if #(
   parameter int SampleBits = lir_pkg::SAMPLE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [SampleBits-1:0] sample_left;
   logic [SampleBits-1:0] sample_right;

   modport source (output valid, cmd, sample_left, sample_right, input ready);
   modport sink   (input valid, cmd, sample_left, sample_right, output ready);
endinterface

interface lir_rsp_if #(
   parameter int SampleBits = lir_pkg::SAMPLE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [SampleBits-1:0] out_left;
   logic [SampleBits-1:0] out_right;
   logic                  last;

   modport source (output valid, out_left, out_right, last, input ready);
   modport sink   (input valid, out_left, out_right, last, output ready);
endinterface

interface lir_csr_if;
   import lir_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] reg_index;
   logic [CSR_DATA_BITS-1:0]  wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

// ===== rtl/lir_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lir_front: frame intake and phase tracking
// Holds csr registers, history and phase, classifies each transaction and
// counts the outputs of a frame, one phase step a cycle, then queues a job.
// ----------------------------------------------------------------------------
module lir_front #(
   parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF,
   parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
   localparam int JOB_BITS   = lir_pkg::job_bits(SAMPLE_BITS, FRAC_BITS)
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire lir_pkg::csr_write_type csr_write,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire                         req_cmd,
   input  wire [SAMPLE_BITS-1:0]       req_left,
   input  wire [SAMPLE_BITS-1:0]       req_right,
   output logic                        job_valid,
   input  wire                         job_ready,
   output logic [JOB_BITS-1:0]         job_data
);
   import lir_pkg::*;

   localparam int PB = FRAC_BITS + PHASE_EXTRA;
   localparam int CW = (STEP_BITS > PB) ? STEP_BITS : PB;
   localparam logic [CW-1:0] STEP_MIN = CW'(1) << (FRAC_BITS - 3);
   localparam logic [CW-1:0] STEP_MAX = CW'(1) << (FRAC_BITS + 3);
   localparam logic [PB-1:0] ONE      = PB'(1) << FRAC_BITS;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] prev_l;
      logic [SAMPLE_BITS-1:0] prev_r;
      logic [SAMPLE_BITS-1:0] cur_l;
      logic [SAMPLE_BITS-1:0] cur_r;
      logic [PB-1:0]          phase;
      logic [PB-1:0]          step;
      logic [CNT_BITS-1:0]    count;
      logic                   mono;
   } job_type;

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_RUN  = 2'b10
   } front_state_type;

   front_state_type        state_ff, state_in;
   logic [STEP_BITS-1:0]   step_cfg_ff, step_cfg_in;
   logic                   stereo_ff, stereo_in;
   logic [SAMPLE_BITS-1:0] prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic [SAMPLE_BITS-1:0] cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic [PB-1:0]          phase_ff, phase_in, phase0_ff, phase0_in;
   logic [PB-1:0]          step_ff, step_in, acc_ff, acc_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   primed_ff, primed_in, mono_ff, mono_in;

   logic [CW-1:0]          step_wide, step_clamp;
   logic                   done;
   job_type                job;

   assign step_wide  = CW'(step_cfg_ff);
   assign step_clamp = (step_wide < STEP_MIN) ? STEP_MIN :
                       (step_wide > STEP_MAX) ? STEP_MAX : step_wide;

   assign req_ready = (state_ff == F_IDLE);
   assign done      = (acc_ff >= ONE) || (cnt_ff == CNT_BITS'(MAX_OUT));
   assign job_valid = (state_ff == F_RUN) && done;

   always_comb begin
      job.prev_l = prev_l_ff;
      job.prev_r = prev_r_ff;
      job.cur_l  = cur_l_ff;
      job.cur_r  = cur_r_ff;
      job.phase  = phase0_ff;
      job.step   = step_ff;
      job.count  = cnt_ff;
      job.mono   = mono_ff;
   end
   assign job_data = job;

   always_comb begin
      state_in    = state_ff;
      step_cfg_in = step_cfg_ff;
      stereo_in   = stereo_ff;
      prev_l_in   = prev_l_ff;
      prev_r_in   = prev_r_ff;
      cur_l_in    = cur_l_ff;
      cur_r_in    = cur_r_ff;
      phase_in    = phase_ff;
      phase0_in   = phase0_ff;
      step_in     = step_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      primed_in   = primed_ff;
      mono_in     = mono_ff;

      if (csr_write.valid) begin
         case (csr_write.reg_index)
            REG_PHASE_STEP:  step_cfg_in = csr_write.wdata[STEP_BITS-1:0];
            REG_STEREO_MODE: stereo_in   = csr_write.wdata[0];
            default:         ;
         endcase
      end

      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               case (req_cmd)
                  CMD_RESTART: begin
                     prev_l_in = '0;
                     prev_r_in = '0;
                     phase_in  = '0;
                     primed_in = 1'b0;
                  end
                  CMD_FRAME: begin
                     cur_l_in = req_left;
                     cur_r_in = stereo_ff ? req_right : req_left;
                     mono_in  = !stereo_ff;
                     if (!primed_ff) begin
                        prev_l_in = req_left;
                        prev_r_in = stereo_ff ? req_right : req_left;
                        primed_in = 1'b1;
                     end else if (phase_ff >= ONE) begin
                        // frame passes without output
                        phase_in  = phase_ff - ONE;
                        prev_l_in = req_left;
                        prev_r_in = stereo_ff ? req_right : req_left;
                     end else begin
                        phase0_in = phase_ff;
                        step_in   = step_clamp[PB-1:0];
                        acc_in    = phase_ff + step_clamp[PB-1:0];
                        cnt_in    = CNT_BITS'(1);
                        state_in  = F_RUN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         F_RUN: begin
            if (done) begin
               if (job_ready) begin
                  phase_in  = acc_ff - ONE;
                  prev_l_in = cur_l_ff;
                  prev_r_in = cur_r_ff;
                  state_in  = F_IDLE;
               end
            end else begin
               acc_in = acc_ff + step_ff;
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         step_cfg_ff <= STEP_BITS'(65536);
         stereo_ff   <= 1'b1;
         prev_l_ff   <= '0;
         prev_r_ff   <= '0;
         phase_ff    <= '0;
         primed_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         step_cfg_ff <= step_cfg_in;
         stereo_ff   <= stereo_in;
         prev_l_ff   <= prev_l_in;
         prev_r_ff   <= prev_r_in;
         phase_ff    <= phase_in;
         primed_ff   <= primed_in;
      end
      cur_l_ff  <= cur_l_in;
      cur_r_ff  <= cur_r_in;
      phase0_ff <= phase0_in;
      step_ff   <= step_in;
      acc_ff    <= acc_in;
      cnt_ff    <= cnt_in;
      mono_ff   <= mono_in;
   end

endmodule
`default_nettype wire

// ===== rtl/lir_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lir_queue: short job queue between front and back
// Register based fifo with valid/ready on both sides.
// ----------------------------------------------------------------------------
module lir_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = lir_pkg::QUEUE_DEPTH
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              in_valid,
   output logic             in_ready,
   input  wire [WIDTH-1:0]  in_data,
   output logic             out_valid,
   input  wire              out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue holds more jobs than its depth");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count missed a push");

endmodule
`default_nettype wire

// ===== rtl/lir_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lir_back: interpolation engine
// Walks the phase of one job, one output a cycle when not stalled, through a
// registered multiply stage and an add stage that feeds the output register.
// ----------------------------------------------------------------------------
module lir_back #(
   parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF,
   parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
   localparam int JOB_BITS   = lir_pkg::job_bits(SAMPLE_BITS, FRAC_BITS)
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    job_valid,
   output logic                   job_ready,
   input  wire [JOB_BITS-1:0]     job_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_left,
   output logic [SAMPLE_BITS-1:0] rsp_right,
   output logic                   rsp_last
);
   import lir_pkg::*;

   localparam int PB = FRAC_BITS + PHASE_EXTRA;
   localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;
   localparam int DW = SAMPLE_BITS + 2;
   localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] prev_l;
      logic [SAMPLE_BITS-1:0] prev_r;
      logic [SAMPLE_BITS-1:0] cur_l;
      logic [SAMPLE_BITS-1:0] cur_r;
      logic [PB-1:0]          phase;
      logic [PB-1:0]          step;
      logic [CNT_BITS-1:0]    count;
      logic                   mono;
   } job_type;

   job_type                job_ff, job_in, job_head;
   logic                   busy_ff, busy_in;
   logic [CNT_BITS-1:0]    k_ff, k_in;
   logic [PB-1:0]          ph_ff, ph_in;

   logic                   v1_ff, v1_in;
   logic signed [PW-1:0]   prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;
   logic [SAMPLE_BITS-1:0] base_l_ff, base_r_ff;
   logic                   last1_ff, mono1_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] out_l_ff, out_l_in, out_r_ff, out_r_in;
   logic                   last_ff;

   logic                   en1, en2, issue, last_now;
   logic signed [SAMPLE_BITS:0] diff_l, diff_r;
   logic signed [FRAC_BITS:0]   frac;
   logic [PW-1:0]          rnd_l, rnd_r;
   logic [DW-1:0]          sum_l, sum_r;

   assign job_head  = job_data;
   assign job_ready = !busy_ff;

   assign en2      = !rsp_valid_ff || rsp_ready;
   assign en1      = !v1_ff || en2;
   assign issue    = busy_ff && en1;
   assign last_now = (k_ff == CNT_BITS'(job_ff.count - CNT_BITS'(1)));

   // offset of the current sample from the previous one, times the fraction
   assign diff_l = $signed({job_ff.cur_l[SAMPLE_BITS-1], job_ff.cur_l})
                 - $signed({job_ff.prev_l[SAMPLE_BITS-1], job_ff.prev_l});
   assign diff_r = $signed({job_ff.cur_r[SAMPLE_BITS-1], job_ff.cur_r})
                 - $signed({job_ff.prev_r[SAMPLE_BITS-1], job_ff.prev_r});
   assign frac      = $signed({1'b0, ph_ff[FRAC_BITS-1:0]});
   assign prod_l_in = diff_l * frac;
   assign prod_r_in = diff_r * frac;

   // round half up, then floor shift
   assign rnd_l    = prod_l_ff + HALF;
   assign rnd_r    = prod_r_ff + HALF;
   assign sum_l    = {{2{base_l_ff[SAMPLE_BITS-1]}}, base_l_ff} + rnd_l[PW-1:FRAC_BITS];
   assign sum_r    = {{2{base_r_ff[SAMPLE_BITS-1]}}, base_r_ff} + rnd_r[PW-1:FRAC_BITS];
   assign out_l_in = sum_l[SAMPLE_BITS-1:0];
   assign out_r_in = mono1_ff ? sum_l[SAMPLE_BITS-1:0] : sum_r[SAMPLE_BITS-1:0];

   always_comb begin
      job_in       = job_ff;
      busy_in      = busy_ff;
      k_in         = k_ff;
      ph_in        = ph_ff;
      v1_in        = v1_ff;
      rsp_valid_in = rsp_valid_ff;

      if (job_valid && !busy_ff) begin
         job_in  = job_head;
         ph_in   = job_head.phase;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (issue) begin
         ph_in = ph_ff + job_ff.step;
         k_in  = k_ff + CNT_BITS'(1);
         if (last_now) begin
            busy_in = 1'b0;
         end
      end

      if (en1) begin
         v1_in = issue;
      end
      if (en2) begin
         rsp_valid_in = v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         v1_ff        <= v1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff <= job_in;
      k_ff   <= k_in;
      ph_ff  <= ph_in;
      if (issue) begin
         prod_l_ff <= prod_l_in;
         prod_r_ff <= prod_r_in;
         base_l_ff <= job_ff.prev_l;
         base_r_ff <= job_ff.prev_r;
         last1_ff  <= last_now;
         mono1_ff  <= job_ff.mono;
      end
      if (en2 && v1_ff) begin
         out_l_ff <= out_l_in;
         out_r_ff <= out_r_in;
         last_ff  <= last1_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left  = out_l_ff;
   assign rsp_right = out_r_ff;
   assign rsp_last  = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      issue |-> (k_ff < job_ff.count))
      else $error("engine issued past the output count of its job");

endmodule
`default_nettype wire

// ===== rtl/linear_interp_resampler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_interp_resampler: linear interpolation sample rate converter
// Takes stereo or mono frames and gives zero to eight interpolated frames
// per input, carrying history and phase from one frame to the next.
// ----------------------------------------------------------------------------
//   channel  dir  handshake        payload
//   req_ch   in   valid / ready    cmd, sample_left, sample_right
//   rsp_ch   out  valid / ready    out_left, out_right, last
//   csr_ch   in   valid / ready    reg_index, wdata (ready always high)
//
// a frame with outputs holds the front while it counts phase, one step per
// cycle, and until its job is queued; restart, priming and no-output frames
// are taken without leaving the idle state. the back loads a job when idle,
// then issues one output per cycle, unless stalled, via its multiply and output registers.
// reset is synchronous and clears history, phase, queue and pipeline.
// a stalled rsp_ch fills the output and multiply stages, then the two-job
// queue, and only then stops the front.
// ----------------------------------------------------------------------------
module linear_interp_resampler #(
   parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF,
   parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
) (
   input  wire      clock,
   input  wire      reset,
   lir_req_if.sink  req_ch,
   lir_rsp_if.source rsp_ch,
   lir_csr_if.sink  csr_ch
);
   import lir_pkg::*;

   localparam int JOB_BITS = job_bits(SAMPLE_BITS, FRAC_BITS);

   csr_write_type         csr_write;
   logic                  fq_valid, fq_ready, qb_valid, qb_ready;
   logic [JOB_BITS-1:0]   fq_data, qb_data;

   assign csr_ch.ready = 1'b1;
   always_comb begin
      csr_write.valid     = csr_ch.valid;
      csr_write.reg_index = csr_ch.reg_index;
      csr_write.wdata     = csr_ch.wdata;
   end

   lir_front #(
      .FRAC_BITS   (FRAC_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_cmd   (req_ch.cmd),
      .req_left  (req_ch.sample_left),
      .req_right (req_ch.sample_right),
      .job_valid (fq_valid),
      .job_ready (fq_ready),
      .job_data  (fq_data)
   );

   lir_queue #(
      .WIDTH (JOB_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   lir_back #(
      .FRAC_BITS   (FRAC_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job_data  (qb_data),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_left  (rsp_ch.out_left),
      .rsp_right (rsp_ch.out_right),
      .rsp_last  (rsp_ch.last)
   );

endmodule
`default_nettype wire

// ===== dv/tb_linear_interp_resampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_interp_resampler: self-checking regression of the resampler
// Drives frames and restarts under a series of step and channel settings,
// predicts every interpolated output in a scoreboard and checks the output
// stream field by field, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_linear_interp_resampler;
   import lir_pkg::*;

   localparam int SB             = SAMPLE_BITS_DEF;
   localparam int ONE_PHASE      = 1 << FRAC_BITS_DEF;
   localparam int STEP_LOW       = ONE_PHASE >> 3;
   localparam int STEP_HIGH      = ONE_PHASE << 3;
   localparam logic [SB-1:0] SIGN_BIT = SB'(1) << (SB - 1);
   localparam int RANDOM_FRAMES  = 430;
   localparam int CALM_FRAMES    = 60;
   localparam int SETTLE_CYCLES  = 24;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [SB-1:0] left;
      logic [SB-1:0] right;
      logic          last;
   } resampled_frame_type;

   class resample_scoreboard_type;
      logic [STEP_BITS-1:0] step_reg;
      logic                 stereo_reg;
      logic [SB-1:0]        hist_left;   // offset binary
      logic [SB-1:0]        hist_right;
      int unsigned          phase_acc;
      bit                   primed;
      resampled_frame_type  pending[$];
      int errors, frames, restarts, checked, writes;

      function new();
         step_reg   = STEP_BITS'(ONE_PHASE);
         stereo_reg = 1'b1;
         errors = 0; frames = 0; restarts = 0; checked = 0; writes = 0;
         clear_history();
      endfunction

      function void clear_history();
         hist_left  = SIGN_BIT;
         hist_right = SIGN_BIT;
         phase_acc  = 0;
         primed     = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         writes++;
         if (idx == REG_PHASE_STEP) step_reg = data[STEP_BITS-1:0];
         else if (idx == REG_STEREO_MODE) stereo_reg = data[0];
      endfunction

      // rounds half up; a and b in offset binary
      function logic [SB-1:0] blend(logic [SB-1:0] a, logic [SB-1:0] b, int unsigned f);
         longint unsigned wa, wb, acc;
         wa  = a;
         wb  = b;
         acc = wa * (ONE_PHASE - f) + wb * f + (ONE_PHASE >> 1);
         return acc[SB+FRAC_BITS_DEF-1:FRAC_BITS_DEF];
      endfunction

      function void note_frame(logic cmd, logic [SB-1:0] sl, logic [SB-1:0] sr);
         logic [SB-1:0]       cur_left, cur_right;
         int unsigned         eff_step;
         int                  n;
         resampled_frame_type item;
         frames++;
         if (cmd == CMD_RESTART) begin
            restarts++;
            clear_history();
            return;
         end
         cur_left  = sl ^ SIGN_BIT;
         cur_right = stereo_reg ? (sr ^ SIGN_BIT) : cur_left;
         if (!primed) begin
            hist_left  = cur_left;
            hist_right = cur_right;
            primed     = 1;
            return;
         end
         eff_step = step_reg;
         if (eff_step < STEP_LOW) eff_step = STEP_LOW;
         if (eff_step > STEP_HIGH) eff_step = STEP_HIGH;
         n = 0;
         while (phase_acc < ONE_PHASE && n < MAX_OUT) begin
            item.left  = blend(hist_left, cur_left, phase_acc) ^ SIGN_BIT;
            item.right = stereo_reg ? (blend(hist_right, cur_right, phase_acc) ^ SIGN_BIT)
                                    : item.left;
            item.last  = 1'b0;
            pending = {pending, item};
            n++;
            phase_acc += eff_step;
         end
         if (n > 0) pending[pending.size()-1].last = 1'b1;
         phase_acc = (phase_acc >= ONE_PHASE) ? phase_acc - ONE_PHASE : 0;
         hist_left  = cur_left;
         hist_right = cur_right;
      endfunction

      function void compare_field(string name, logic [SB-1:0] want, logic [SB-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
                     $signed(want), $signed(got));
         end
      endfunction

      function void check_output(logic [SB-1:0] l, logic [SB-1:0] r, logic last);
         resampled_frame_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected output transaction, got left %0d right %0d last %0b",
                     $time, $signed(l), $signed(r), last);
            return;
         end
         want = pending.pop_front();
         checked++;
         compare_field("out_left", want.left, l);
         compare_field("out_right", want.right, r);
         compare_field("last", SB'(want.last), SB'(last));
      endfunction

      function void close();
         if (pending.size() != 0) begin
            errors += pending.size();
            $display("%0t: %0d expected output transactions never arrived", $time,
                     pending.size());
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   idle_enable;
   int   ready_count = 0;
   int   idle_cycles = 0;
   resample_scoreboard_type sb;

   lir_req_if req_ch ();
   lir_rsp_if rsp_ch ();
   lir_csr_if csr_ch ();

   linear_interp_resampler u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // output side back-pressure in bursts
   always @(posedge clock) begin
      if (ready_count != 0) begin
         ready_count <= ready_count - 1;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
         rsp_ch.ready <= 1'b0;
         ready_count  <= $urandom_range(0, 15);
      end else begin
         rsp_ch.ready <= 1'b1;
         ready_count  <= $urandom_range(0, 23);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_output(rsp_ch.out_left, rsp_ch.out_right, rsp_ch.last);
         if (req_ch.valid && req_ch.ready)
            sb.note_frame(req_ch.cmd, req_ch.sample_left, req_ch.sample_right);
         if (csr_ch.valid && csr_ch.ready)
            sb.set_reg(csr_ch.reg_index, csr_ch.wdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("linear_interp_resampler regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // called at a rising edge; returns at the edge that accepts the frame
   task automatic send_frame(input logic cmd, input logic [SB-1:0] left,
                             input logic [SB-1:0] right);
      int gap = 0;
      if (idle_enable && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= cmd;
      req_ch.sample_left  <= left;
      req_ch.sample_right <= right;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data, input bit hold);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wdata     <= data;
      do @(posedge clock); while (!csr_ch.ready);
      if (!hold) csr_ch.valid <= 1'b0;
   endtask

   // all outputs delivered, then room for frames that give none
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [STEP_BITS-1:0] step, input logic stereo);
      settle_block();
      write_csr(REG_PHASE_STEP, CSR_DATA_BITS'(step), 1'b1);
      write_csr(REG_STEREO_MODE, CSR_DATA_BITS'(stereo), 1'b0);
   endtask

   function automatic logic [STEP_BITS-1:0] pick_step();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 6))
               0: return '0;
               1: return STEP_BITS'(1);
               2: return STEP_BITS'(STEP_LOW - 1);
               3: return STEP_BITS'(STEP_LOW);
               4: return STEP_BITS'(STEP_HIGH);
               5: return STEP_BITS'(STEP_HIGH + 1);
               default: return '1;
            endcase
         end
         1, 2, 3: return STEP_BITS'($urandom_range(STEP_LOW, ONE_PHASE));
         4, 5, 6: return STEP_BITS'($urandom_range(ONE_PHASE, STEP_HIGH));
         7: return STEP_BITS'(ONE_PHASE);
         8: return STEP_BITS'($urandom_range(0, (1 << STEP_BITS) - 1));
         default: return STEP_BITS'($urandom_range(STEP_LOW, 2 * STEP_LOW));
      endcase
   endfunction

   function automatic logic [SB-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return {1'b0, {(SB-1){1'b1}}};
         1: return SIGN_BIT;
         2: return '0;
         default: return SB'($urandom_range(0, (1 << SB) - 1));
      endcase
   endfunction

   task automatic play_random(input int count);
      logic cmd;
      for (int i = 0; i < count; i++) begin
         cmd = ($urandom_range(0, 24) == 0) ? CMD_RESTART : CMD_FRAME;
         send_frame(cmd, pick_sample(), pick_sample());
      end
   endtask

   initial begin
      int remaining;
      int chunk;
      sb = new();
      idle_enable         = 1'b1;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.cmd          <= CMD_FRAME;
      req_ch.sample_left  <= '0;
      req_ch.sample_right <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.reg_index    <= REG_PHASE_STEP;
      csr_ch.wdata        <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: unit step, stereo; first frame only primes
      send_frame(CMD_FRAME, 16'h7FFF, 16'h8000);
      send_frame(CMD_FRAME, 16'h8000, 16'h7FFF);
      send_frame(CMD_FRAME, 16'h0000, 16'h0000);

      // smallest step, eight outputs per frame, full swing
      apply_settings(STEP_BITS'(STEP_LOW), 1'b1);
      send_frame(CMD_FRAME, 16'h8000, 16'h7FFF);
      send_frame(CMD_FRAME, 16'h7FFF, 16'h8000);
      send_frame(CMD_RESTART, 16'h1234, 16'h4321);
      send_frame(CMD_FRAME, 16'd1000, -16'sd1000);
      send_frame(CMD_FRAME, 16'hFFFF, 16'h0001);

      // zero step saturates to the minimum; mono ignores the right sample
      apply_settings('0, 1'b0);
      send_frame(CMD_FRAME, 16'd12345, 16'hFFF9);
      send_frame(CMD_FRAME, 16'h8000, 16'h7FFF);

      // all-ones step saturates to eight: mostly frames with no output
      apply_settings('1, 1'b1);
      for (int i = 0; i < 5; i++) send_frame(CMD_FRAME, 16'(i * 7919), 16'(-i * 4111));

      apply_settings(STEP_BITS'(3 * ONE_PHASE / 2), 1'b1);
      send_frame(CMD_RESTART, 16'h7FFF, 16'h7FFF);
      for (int i = 0; i < 4; i++)
         send_frame(CMD_FRAME, i[0] ? 16'h7FFF : 16'h8000, i[0] ? 16'h8000 : 16'h7FFF);

      apply_settings(STEP_BITS'(STEP_LOW - 1), 1'b0);
      send_frame(CMD_FRAME, 16'h7FFF, 16'h0000);
      send_frame(CMD_FRAME, 16'h8000, 16'h5555);

      apply_settings(STEP_BITS'(STEP_HIGH + 1), 1'b1);
      send_frame(CMD_FRAME, 16'h00FF, 16'hFF00);
      send_frame(CMD_FRAME, 16'hAAAA, 16'h5555);

      remaining = RANDOM_FRAMES;
      while (remaining > 0) begin
         chunk = $urandom_range(25, 50);
         if (remaining <= CALM_FRAMES || chunk > remaining) chunk = remaining;
         apply_settings(pick_step(), 1'($urandom_range(0, 1)));
         if (remaining <= CALM_FRAMES) idle_enable = 1'b0;
         play_random(chunk);
         remaining -= chunk;
      end

      settle_block();
      sb.close();
      $display("covered %0d input transactions (%0d restarts) under %0d register writes",
               sb.frames, sb.restarts, sb.writes);
      $display("checked %0d interpolated output transactions, %0d errors", sb.checked,
               sb.errors);
      if (sb.errors == 0) begin
         $display("linear_interp_resampler regression: pass");
      end else begin
         $display("linear_interp_resampler regression: fail");
      end
      $finish;
   end

endmodule
